/* hw/rtl/assert_macros.svh */
// assertion macros used by pfsr_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication with asynchronous reset disable
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
// clocked next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`endif

/* hw/rtl/pfsr_pkg.sv */
// package for the polyline resampler: fixed widths and register codes
// no dependencies
package pfsr_pkg;
	localparam int SpacingBits = 24;
	localparam int DistBits = 26;
	localparam logic [31:0] SpacingReset = 32'd10000;
	localparam logic [0:0] RegSpacing = 1'b0;
endpackage

/* hw/rtl/pfsr_if.sv */
// valid/ready channel interfaces for vertex and waypoint beats
// no dependencies
interface pfsr_vtx_if #(parameter int CW = 24);
	logic valid;
	logic ready;
	logic signed [CW-1:0] vx;
	logic signed [CW-1:0] vy;
	logic signed [CW-1:0] vz;
	logic starts_polyline;
	modport source (output valid, vx, vy, vz, starts_polyline, input ready);
	modport sink (input valid, vx, vy, vz, starts_polyline, output ready);
endinterface

interface pfsr_wpt_if #(parameter int CW = 24);
	logic valid;
	logic ready;
	logic signed [CW-1:0] wx;
	logic signed [CW-1:0] wy;
	logic signed [CW-1:0] wz;
	logic last_of_run;
	logic truncated;
	modport source (output valid, wx, wy, wz, last_of_run, truncated, input ready);
	modport sink (input valid, wx, wy, wz, last_of_run, truncated, output ready);
endinterface

/* hw/rtl/polyline_fixed_spacing_resampler_top.sv */
// polyline resampler: vertex in, waypoints out, one shared add/sub unit
// depends on pfsr_pkg and pfsr_if
// steps: a start vertex beat is loaded in S_START once the output is free; a segment goes through
// S_MUL (squares), S_SQRT (root), S_CNT (point count), S_DIV (six divides) and S_EMIT (beats)
// throughput: one vertex at a time; not ready from acceptance until the last beat is loaded or no point is due
// reset: arst_n asynchronous, clears control state and sets the spacing register to 10000
module polyline_fixed_spacing_resampler_top import pfsr_pkg::*; #(
	parameter int MAX_POINTS_PER_VERTEX = 64,
	parameter int COORD_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	pfsr_vtx_if.sink vin,
	pfsr_wpt_if.source wout,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int CW = COORD_BITS;
	localparam int MW = CW + 1;
	localparam int SQW = 2 * MW + 2;
	localparam int LW = MW + 1;
	localparam int PW = MW + SpacingBits;
	localparam int AW = (SQW > PW + 3) ? SQW : PW + 3;
	localparam int PCW = $clog2(MAX_POINTS_PER_VERTEX + 2);
	localparam int SCW = $clog2(PW + 1);
	localparam int RTW = (SQW + 1) / 2;
	localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_SQRT = 4'd2, S_CNT = 4'd3,
		S_DIV = 4'd4, S_EMIT = 4'd5, S_START = 4'd6;

	logic [3:0] state_q;
	logic [SpacingBits-1:0] spacing_q;
	logic signed [CW-1:0] px_q [3];
	logic signed [CW-1:0] nx_q [3];
	logic [MW-1:0] mag_q [3];
	logic neg_q [3];
	logic [DistBits-1:0] dist_q;
	logic have_prev_q;
	logic [SQW-1:0] acc_q;
	logic [MW-1:0] mcand_q;
	logic [SQW-1:0] msh_q;
	logic [SCW-1:0] cnt_q;
	logic [1:0] axis_q;
	logic [RTW-1:0] root_q;
	logic [RTW+1:0] rem_q;
	logic [SQW-1:0] rad_q;
	logic [LW-1:0] len_q;
	logic [SpacingBits-1:0] sp_q;
	logic [SpacingBits:0] s1_q;
	logic [PW+1:0] sacc_q;
	logic [PCW-1:0] npts_q;
	logic trunc_q;
	logic [PW-1:0] dnum_q;
	logic [PW-1:0] quo_q;
	logic [LW:0] drem_q;
	logic div_step_q;
	logic [PW-1:0] q_q [3];
	logic [LW-1:0] r_q [3];
	logic [PW-1:0] sq_q [3];
	logic [LW-1:0] sr_q [3];
	logic [PCW-1:0] k_q;
	logic [2:0] dsel_q;

	logic wr_en;
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign prdata = (paddr[1:0] == {RegSpacing, 1'b0}) ?
		{{(32-SpacingBits){1'b0}}, spacing_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SpacingReset[SpacingBits-1:0];
		end else if (wr_en && paddr[1] == RegSpacing) begin
			spacing_q <= pwdata[SpacingBits-1:0];
		end
	end

	assign vin.ready = (state_q == S_IDLE);

	// shared adder: one wide add/sub per cycle
	logic [AW-1:0] add_a, add_b, add_y;
	logic add_sub;
	assign add_y = add_sub ? add_a - add_b : add_a + add_b;

	logic [RTW+1:0] trial;
	logic [RTW+1:0] rem_sh;
	logic [LW:0] drem_sh;
	logic [LW-1:0] rn [3];
	logic [PW-1:0] qn [3];
	logic [PW-1:0] rd [3];
	logic signed [CW-1:0] c [3];
	logic [MW:0] dd [3];
	logic [MW-1:0] amag [3];

	always_comb begin
		add_a = '0;
		add_b = '0;
		add_sub = 1'b0;
		rem_sh = {rem_q[RTW-1:0], rad_q[SQW-1 -: 2]};
		trial = {root_q, 2'b01};
		drem_sh = {drem_q[LW-1:0], dnum_q[PW-1]};
		unique case (state_q)
			S_MUL: begin
				add_a = AW'(acc_q);
				add_b = AW'(msh_q);
			end
			S_SQRT: begin
				add_a = AW'(rem_sh);
				add_b = AW'(trial);
				add_sub = 1'b1;
			end
			S_CNT: begin
				add_a = AW'(sacc_q);
				add_b = AW'(sp_q);
			end
			S_DIV: begin
				add_a = AW'(drem_sh);
				add_b = AW'(len_q);
				add_sub = 1'b1;
			end
			default: ;
		endcase
		for (int a = 0; a < 3; a++) begin
			dd[a] = {nx_q[a][CW-1], nx_q[a]} - {px_q[a][CW-1], px_q[a]};
			amag[a] = dd[a][MW-1] ? MW'(-dd[a]) : MW'(dd[a]);
			rd[a] = q_q[a] + PW'({r_q[a], 1'b0} >= {1'b0, len_q} && len_q != 0);
			c[a] = neg_q[a] ? px_q[a] - CW'(rd[a]) : px_q[a] + CW'(rd[a]);
			rn[a] = r_q[a] + sr_q[a];
			qn[a] = q_q[a] + sq_q[a];
			if (len_q != 0 && rn[a] >= len_q) begin
				rn[a] = rn[a] - len_q;
				qn[a] = qn[a] + PW'(1);
			end
		end
	end

	logic [1:0] dsel_axis;
	assign dsel_axis = dsel_q[2:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			have_prev_q <= 1'b0;
			dist_q <= '0;
			wout.valid <= 1'b0;
			for (int a = 0; a < 3; a++) px_q[a] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (vin.valid) begin
						nx_q[0] <= vin.vx;
						nx_q[1] <= vin.vy;
						nx_q[2] <= vin.vz;
						if (vin.starts_polyline || !have_prev_q) begin
							state_q <= S_START;
						end else begin
							state_q <= S_MUL;
							axis_q <= 2'd0;
							cnt_q <= '0;
							acc_q <= '0;
						end
					end
				end
				S_START: begin
					if (!wout.valid || wout.ready) begin
						wout.valid <= 1'b1;
						wout.wx <= nx_q[0];
						wout.wy <= nx_q[1];
						wout.wz <= nx_q[2];
						wout.last_of_run <= 1'b1;
						wout.truncated <= 1'b0;
						for (int a = 0; a < 3; a++) px_q[a] <= nx_q[a];
						dist_q <= '0;
						have_prev_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MUL: begin
					// shift-add square of one axis magnitude, accumulated
					if (cnt_q == '0) begin
						neg_q[axis_q] <= dd[axis_q][MW-1];
						mag_q[axis_q] <= amag[axis_q];
						mcand_q <= amag[axis_q];
						msh_q <= SQW'(amag[axis_q]);
						cnt_q <= cnt_q + SCW'(1);
					end else begin
						if (mcand_q[0]) acc_q <= add_y[SQW-1:0];
						mcand_q <= mcand_q >> 1;
						msh_q <= msh_q << 1;
						if (cnt_q == SCW'(MW)) begin
							cnt_q <= '0;
							if (axis_q == 2'd2) begin
								state_q <= S_SQRT;
							end
							axis_q <= axis_q + 2'd1;
						end else begin
							cnt_q <= cnt_q + SCW'(1);
						end
					end
				end
				default: ;
			endcase
			if (wout.valid && wout.ready && state_q != S_START && state_q != S_EMIT)
				wout.valid <= 1'b0;
			if (state_q == S_MUL && cnt_q == SCW'(MW) && axis_q == 2'd2) begin
				root_q <= '0;
				rem_q <= '0;
			end
			if (state_q == S_SQRT) begin
				rad_q <= rad_q << 2;
				if (!add_y[AW-1] && add_y[RTW+1:0] <= rem_sh) begin
					rem_q <= add_y[RTW+1:0];
					root_q <= {root_q[RTW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					root_q <= {root_q[RTW-2:0], 1'b0};
				end
				if (cnt_q == SCW'(RTW - 1)) begin
					state_q <= S_CNT;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + SCW'(1);
				end
			end
			if (state_q == S_CNT) begin
				if (cnt_q == '0) begin
					len_q <= LW'(root_q);
					sp_q <= (spacing_q == '0) ? SpacingBits'(1) : spacing_q;
					cnt_q <= SCW'(1);
					npts_q <= '0;
				end else if (cnt_q == SCW'(1)) begin
					s1_q <= {1'b0, sp_q} - ((DistBits'(sp_q) > dist_q) ?
						(SpacingBits+1)'(dist_q) : {1'b0, sp_q});
					cnt_q <= SCW'(2);
				end else if (cnt_q == SCW'(2)) begin
					sacc_q <= (PW+2)'(s1_q);
					cnt_q <= SCW'(3);
				end else begin
					if (sacc_q <= (PW+2)'(len_q) && npts_q <= PCW'(MAX_POINTS_PER_VERTEX)) begin
						npts_q <= npts_q + PCW'(1);
						sacc_q <= add_y[PW+1:0];
					end else begin
						trunc_q <= npts_q > PCW'(MAX_POINTS_PER_VERTEX);
						if (npts_q > PCW'(MAX_POINTS_PER_VERTEX)) begin
							npts_q <= PCW'(MAX_POINTS_PER_VERTEX);
							dist_q <= '0;
						end else if (npts_q == '0) begin
							dist_q <= DistBits'(((SpacingBits+1)'(sp_q) - s1_q)) + DistBits'(len_q);
						end else begin
							dist_q <= DistBits'((PW+2)'(len_q) - (sacc_q - (PW+2)'(sp_q)));
						end
						if (npts_q == '0) begin
							state_q <= S_IDLE;
							for (int a = 0; a < 3; a++) px_q[a] <= nx_q[a];
						end else begin
							state_q <= S_DIV;
							dsel_q <= '0;
							div_step_q <= 1'b0;
						end
					end
				end
			end
			if (state_q == S_DIV) begin
				// restoring divide, one quotient bit a cycle; six divides
				if (!div_step_q) begin
					dnum_q <= dsel_q[0] ? PW'(sp_q) * PW'(mag_q[dsel_axis]) :
						PW'(s1_q) * PW'(mag_q[dsel_axis]);
					drem_q <= '0;
					cnt_q <= '0;
					div_step_q <= 1'b1;
				end else begin
					dnum_q <= dnum_q << 1;
					if (!add_y[AW-1]) begin
						drem_q <= add_y[LW:0];
						quo_q <= {quo_q[PW-2:0], 1'b1};
					end else begin
						drem_q <= drem_sh;
						quo_q <= {quo_q[PW-2:0], 1'b0};
					end
					if (cnt_q == SCW'(PW - 1)) begin
						div_step_q <= 1'b0;
						if (dsel_q == 3'd5) begin
							state_q <= S_EMIT;
							k_q <= '0;
						end
						dsel_q <= dsel_q + 3'd1;
					end else begin
						cnt_q <= cnt_q + SCW'(1);
					end
				end
			end
			if (state_q == S_DIV && div_step_q && cnt_q == SCW'(PW - 1)) begin
				if (len_q == '0) begin
					if (dsel_q[0]) begin
						sq_q[dsel_axis] <= '0;
						sr_q[dsel_axis] <= '0;
					end else begin
						q_q[dsel_axis] <= '0;
						r_q[dsel_axis] <= '0;
					end
				end else if (dsel_q[0]) begin
					sq_q[dsel_axis] <= {quo_q[PW-2:0], !add_y[AW-1]};
					sr_q[dsel_axis] <= !add_y[AW-1] ? add_y[LW-1:0] : drem_sh[LW-1:0];
				end else begin
					q_q[dsel_axis] <= {quo_q[PW-2:0], !add_y[AW-1]};
					r_q[dsel_axis] <= !add_y[AW-1] ? add_y[LW-1:0] : drem_sh[LW-1:0];
				end
			end
			if (state_q == S_EMIT) begin
				if (!wout.valid || wout.ready) begin
					wout.valid <= 1'b1;
					wout.wx <= c[0];
					wout.wy <= c[1];
					wout.wz <= c[2];
					wout.last_of_run <= (k_q == npts_q - PCW'(1));
					wout.truncated <= trunc_q && (k_q == npts_q - PCW'(1));
					for (int a = 0; a < 3; a++) begin
						q_q[a] <= qn[a];
						r_q[a] <= rn[a];
					end
					k_q <= k_q + PCW'(1);
					if (k_q == npts_q - PCW'(1)) begin
						state_q <= S_IDLE;
						for (int a = 0; a < 3; a++) px_q[a] <= nx_q[a];
					end
				end
			end
			if (state_q == S_MUL && cnt_q == SCW'(MW) && axis_q == 2'd2)
				rad_q <= mcand_q[0] ? add_y[SQW-1:0] : acc_q;
		end
	end
endmodule

/* hw/rtl/pfsr_checker.sv */
// port-level checks for the polyline resampler
// depends on assert_macros.svh and the top level ports
`include "assert_macros.svh"
module pfsr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last,
	input logic out_trunc
);
	`CHK_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "ready after accept")
	`CHK_IMPL(a_trunc_is_last, clk, arst_n, out_valid && out_trunc, out_last, "truncated not last")
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "output beat dropped")
endmodule

bind polyline_fixed_spacing_resampler_top pfsr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(vin.valid), .in_ready(vin.ready),
	.out_valid(wout.valid), .out_ready(wout.ready), .out_last(wout.last_of_run),
	.out_trunc(wout.truncated)
);
